@@ hdl/vertex_leader_clustering_assert.svh @@
// Assertion macros for the vertex clustering block.
`ifndef VERTEX_LEADER_CLUSTERING_ASSERT_SVH
`define VERTEX_LEADER_CLUSTERING_ASSERT_SVH

// Check a property while out of reset.
`define VLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every edge, reset included.
`define VLC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hdl/vlc_pkg.sv @@
`timescale 1ns / 1ps
package vlc_pkg;

  localparam int MaxVertices = 64;
  localparam int VidxW       = $clog2(MaxVertices);
  localparam int VtotW       = $clog2(MaxVertices + 1);
  localparam int CoordW      = 24;
  localparam int TolW        = 24;
  localparam int CntW        = 16;
  localparam int IdxW        = 16;
  localparam int OutVidxW    = 6;
  localparam int ProdW       = CntW + 1 + CoordW;
  localparam int NumW        = ProdW + 1;
  localparam int DvdW        = ProdW;
  localparam int DenW        = CntW + 1;
  localparam int SqW         = 2 * TolW;
  localparam int SumW        = SqW + 2;
  localparam int DivCntW     = $clog2(DvdW);
  localparam int FifoDepth   = 2;

  typedef enum logic [3:0] {
    S_IDLE, S_TSQ, S_RD, S_CHK, S_SQ, S_CMP,
    S_MUL, S_DIV, S_FIN, S_WB, S_MISS, S_OUT
  } state_e;

  typedef struct packed {
    logic                     first_of_event;
    logic                     is_shower;
    logic [IdxW-1:0]          item_index;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
  } item_t;

  typedef struct packed {
    logic [OutVidxW-1:0]      vertex_index;
    logic                     created;
    logic                     table_full;
    logic [CntW-1:0]          member_count;
    logic signed [CoordW-1:0] centroid_x;
    logic signed [CoordW-1:0] centroid_y;
    logic signed [CoordW-1:0] centroid_z;
    logic [IdxW-1:0]          echo_index;
    logic                     echo_kind;
  } res_t;

endpackage

@@ hdl/vlc_front.sv @@
`timescale 1ns / 1ps
module vlc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vlc_pkg::item_t item_i,
  output logic          full_o,
  input  logic          take_i,
  output logic          avail_o,
  output vlc_pkg::item_t head_o
);

  localparam int PtrW = $clog2(vlc_pkg::FifoDepth);

  vlc_pkg::item_t       buf_q [vlc_pkg::FifoDepth];
  logic [PtrW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]        cnt_q, cnt_d;
  logic                 do_wr, do_rd;

  assign full_o  = (cnt_q == (PtrW+1)'(vlc_pkg::FifoDepth));
  assign avail_o = (cnt_q != '0);
  assign head_o  = buf_q[rd_q];
  assign do_wr   = push_i && !full_o;
  assign do_rd   = take_i && avail_o;

  always_comb begin
    wr_d  = do_wr ? wr_q + PtrW'(1) : wr_q;
    rd_d  = do_rd ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + (PtrW+1)'(do_wr) - (PtrW+1)'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      buf_q[wr_q] <= item_i;
    end
  end

endmodule

@@ hdl/vlc_back.sv @@
`timescale 1ns / 1ps
module vlc_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [vlc_pkg::TolW-1:0]  tol_i,
  input  logic                      avail_i,
  input  vlc_pkg::item_t            head_i,
  output logic                      take_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output vlc_pkg::res_t             res_o
);

  localparam int CW = vlc_pkg::CoordW;

  vlc_pkg::state_e state_q, state_d;

  logic [3*CW-1:0]                cen_mem [vlc_pkg::MaxVertices];
  logic [vlc_pkg::CntW-1:0]       cnt_mem [vlc_pkg::MaxVertices];

  vlc_pkg::item_t                 item_q;
  logic [vlc_pkg::VtotW-1:0]      total_q, v_q;
  logic [3*CW-1:0]                cen_q;
  logic [vlc_pkg::CntW-1:0]       n_q;
  logic [vlc_pkg::TolW-1:0]       diff_q [3];
  logic [vlc_pkg::SumW-1:0]       sum_q;
  logic [vlc_pkg::SqW-1:0]        tolsq_q;
  logic [1:0]                     k_q;
  logic [vlc_pkg::DvdW-1:0]       dvd_q;
  logic [vlc_pkg::DenW-1:0]       rem_q;
  logic                           neg_q;
  logic [vlc_pkg::DivCntW-1:0]    dcnt_q;
  logic signed [CW-1:0]           mean_q [3];
  vlc_pkg::res_t                  pend_q, out_q;
  logic                           out_valid_q;

  logic signed [CW-1:0]           p_ax [3];
  logic signed [CW-1:0]           c_ax [3];
  logic [CW:0]                    adiff [3];
  logic                           reject;
  logic                           last_v;
  logic                           out_free;
  logic [vlc_pkg::DenW-1:0]       den;
  logic signed [vlc_pkg::ProdW-1:0] prod;
  logic signed [vlc_pkg::NumW-1:0]  num;
  logic [vlc_pkg::NumW-1:0]       num_mag;
  logic [vlc_pkg::DenW:0]         rem_sh;
  logic                           qbit;
  logic [vlc_pkg::CntW-1:0]       n_next;
  logic signed [CW:0]             sd [3];

  assign p_ax[0] = item_q.pos_x;
  assign p_ax[1] = item_q.pos_y;
  assign p_ax[2] = item_q.pos_z;
  assign c_ax[0] = cen_q[3*CW-1:2*CW];
  assign c_ax[1] = cen_q[2*CW-1:CW];
  assign c_ax[2] = cen_q[CW-1:0];

  always_comb begin
    reject = 1'b0;
    for (int k = 0; k < 3; k++) begin
      sd[k]    = {p_ax[k][CW-1], p_ax[k]} - {c_ax[k][CW-1], c_ax[k]};
      adiff[k] = sd[k][CW] ? (CW+1)'(-sd[k]) : sd[k];
      if (adiff[k] > {1'b0, tol_i}) reject = 1'b1;
    end
  end

  assign last_v   = (v_q + vlc_pkg::VtotW'(1) >= total_q);
  assign out_free = !out_valid_q || pop_i;
  assign den      = {1'b0, n_q} + vlc_pkg::DenW'(1);
  assign n_next   = (n_q == '1) ? n_q : n_q + vlc_pkg::CntW'(1);

  // running mean numerator n*c + p for the current axis
  always_comb begin
    prod    = $signed({1'b0, n_q}) * c_ax[k_q];
    num     = vlc_pkg::NumW'(prod) + vlc_pkg::NumW'(p_ax[k_q]);
    num_mag = num[vlc_pkg::NumW-1] ? vlc_pkg::NumW'(-num) : num;
    rem_sh  = {rem_q, dvd_q[vlc_pkg::DvdW-1]};
    qbit    = (rem_sh >= {1'b0, den});
  end

  always_comb begin
    state_d = state_q;
    take_o  = 1'b0;
    unique case (state_q)
      vlc_pkg::S_IDLE: if (avail_i) begin
        take_o  = 1'b1;
        state_d = vlc_pkg::S_TSQ;
      end
      vlc_pkg::S_TSQ: state_d = (total_q == '0) ? vlc_pkg::S_MISS : vlc_pkg::S_RD;
      vlc_pkg::S_RD:  state_d = vlc_pkg::S_CHK;
      vlc_pkg::S_CHK: begin
        if (!reject) state_d = vlc_pkg::S_SQ;
        else if (last_v) state_d = vlc_pkg::S_MISS;
        else state_d = vlc_pkg::S_RD;
      end
      vlc_pkg::S_SQ: if (k_q == 2'd2) state_d = vlc_pkg::S_CMP;
      vlc_pkg::S_CMP: begin
        if (sum_q <= {2'b00, tolsq_q}) state_d = vlc_pkg::S_MUL;
        else if (last_v) state_d = vlc_pkg::S_MISS;
        else state_d = vlc_pkg::S_RD;
      end
      vlc_pkg::S_MUL: state_d = vlc_pkg::S_DIV;
      vlc_pkg::S_DIV: if (dcnt_q == vlc_pkg::DivCntW'(vlc_pkg::DvdW - 1)) begin
        state_d = vlc_pkg::S_FIN;
      end
      vlc_pkg::S_FIN: state_d = (k_q == 2'd2) ? vlc_pkg::S_WB : vlc_pkg::S_MUL;
      vlc_pkg::S_WB:   state_d = vlc_pkg::S_OUT;
      vlc_pkg::S_MISS: state_d = vlc_pkg::S_OUT;
      vlc_pkg::S_OUT:  if (out_free) state_d = vlc_pkg::S_IDLE;
      default:         state_d = vlc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vlc_pkg::S_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take_o && head_i.first_of_event) total_q <= '0;
      else if (state_q == vlc_pkg::S_MISS && total_q != vlc_pkg::VtotW'(vlc_pkg::MaxVertices)) begin
        total_q <= total_q + vlc_pkg::VtotW'(1);
      end
      if (state_q == vlc_pkg::S_OUT && out_free) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      vlc_pkg::S_IDLE: if (take_o) item_q <= head_i;
      vlc_pkg::S_TSQ: begin
        tolsq_q <= tol_i * tol_i;
        v_q     <= '0;
      end
      vlc_pkg::S_RD: begin
        cen_q <= cen_mem[v_q[vlc_pkg::VidxW-1:0]];
        n_q   <= cnt_mem[v_q[vlc_pkg::VidxW-1:0]];
      end
      vlc_pkg::S_CHK: begin
        for (int k = 0; k < 3; k++) diff_q[k] <= adiff[k][CW-1:0];
        sum_q <= '0;
        k_q   <= 2'd0;
        if (reject) v_q <= v_q + vlc_pkg::VtotW'(1);
      end
      vlc_pkg::S_SQ: begin
        sum_q <= sum_q + vlc_pkg::SumW'(diff_q[k_q]) * vlc_pkg::SumW'(diff_q[k_q]);
        k_q   <= k_q + 2'd1;
      end
      vlc_pkg::S_CMP: begin
        k_q <= 2'd0;
        if (sum_q > {2'b00, tolsq_q}) v_q <= v_q + vlc_pkg::VtotW'(1);
      end
      vlc_pkg::S_MUL: begin
        // add half the divisor so the quotient rounds to nearest
        dvd_q  <= vlc_pkg::DvdW'(num_mag) + vlc_pkg::DvdW'(den >> 1);
        neg_q  <= num[vlc_pkg::NumW-1];
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      vlc_pkg::S_DIV: begin
        rem_q  <= qbit ? vlc_pkg::DenW'(rem_sh - {1'b0, den}) : rem_sh[vlc_pkg::DenW-1:0];
        dvd_q  <= {dvd_q[vlc_pkg::DvdW-2:0], qbit};
        dcnt_q <= dcnt_q + vlc_pkg::DivCntW'(1);
      end
      vlc_pkg::S_FIN: begin
        mean_q[k_q] <= neg_q ? -$signed(dvd_q[CW-1:0]) : $signed(dvd_q[CW-1:0]);
        k_q         <= k_q + 2'd1;
      end
      vlc_pkg::S_WB: begin
        cen_mem[v_q[vlc_pkg::VidxW-1:0]] <= {mean_q[0], mean_q[1], mean_q[2]};
        cnt_mem[v_q[vlc_pkg::VidxW-1:0]] <= n_next;
        pend_q.vertex_index <= vlc_pkg::OutVidxW'(v_q);
        pend_q.created      <= 1'b0;
        pend_q.table_full   <= 1'b0;
        pend_q.member_count <= n_next;
        pend_q.centroid_x   <= mean_q[0];
        pend_q.centroid_y   <= mean_q[1];
        pend_q.centroid_z   <= mean_q[2];
        pend_q.echo_index   <= item_q.item_index;
        pend_q.echo_kind    <= item_q.is_shower;
      end
      vlc_pkg::S_MISS: begin
        pend_q.echo_index <= item_q.item_index;
        pend_q.echo_kind  <= item_q.is_shower;
        if (total_q == vlc_pkg::VtotW'(vlc_pkg::MaxVertices)) begin
          pend_q.vertex_index <= '0;
          pend_q.created      <= 1'b0;
          pend_q.table_full   <= 1'b1;
          pend_q.member_count <= '0;
          pend_q.centroid_x   <= '0;
          pend_q.centroid_y   <= '0;
          pend_q.centroid_z   <= '0;
        end else begin
          cen_mem[total_q[vlc_pkg::VidxW-1:0]] <= {item_q.pos_x, item_q.pos_y, item_q.pos_z};
          cnt_mem[total_q[vlc_pkg::VidxW-1:0]] <= vlc_pkg::CntW'(1);
          pend_q.vertex_index <= vlc_pkg::OutVidxW'(total_q);
          pend_q.created      <= 1'b1;
          pend_q.table_full   <= 1'b0;
          pend_q.member_count <= vlc_pkg::CntW'(1);
          pend_q.centroid_x   <= item_q.pos_x;
          pend_q.centroid_y   <= item_q.pos_y;
          pend_q.centroid_z   <= item_q.pos_z;
        end
      end
      vlc_pkg::S_OUT: if (out_free) out_q <= pend_q;
      default: ;
    endcase
  end

  assign empty_o = !out_valid_q;
  assign res_o   = out_q;

endmodule

@@ hdl/vertex_leader_clustering.sv @@
`timescale 1ns / 1ps
// Channel   Handshake             Word
// input     push_i / full_o       event flag, kind, index, x/y/z start point
// result    pop_i / empty_o       vertex, flags, count, centroid, echoes
// config    cfg_we_i              tolerance (24 bit)
// An item scans the stored centroids until a match: a centroid is rejected when one axis is
// out of tolerance, else the full squared distance is tested; a match runs a serial mean
// divide per axis (one shared unit).
// A two-word input queue and a one-word result register let both sides stall.
// Reset (async, low) empties the queues and the vertex table; tolerance is 256.
module vertex_leader_clustering (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic                          first_of_event_i,
  input  logic                          is_shower_i,
  input  logic [vlc_pkg::IdxW-1:0]      item_index_i,
  input  logic signed [vlc_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [vlc_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [vlc_pkg::CoordW-1:0] pos_z_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output logic [vlc_pkg::OutVidxW-1:0]  vertex_index_o,
  output logic                          created_o,
  output logic                          table_full_o,
  output logic [vlc_pkg::CntW-1:0]      member_count_o,
  output logic signed [vlc_pkg::CoordW-1:0] centroid_x_o,
  output logic signed [vlc_pkg::CoordW-1:0] centroid_y_o,
  output logic signed [vlc_pkg::CoordW-1:0] centroid_z_o,
  output logic [vlc_pkg::IdxW-1:0]      echo_index_o,
  output logic                          echo_kind_o,
  input  logic                          cfg_we_i,
  input  logic [vlc_pkg::TolW-1:0]      cfg_wdata_i
);

  logic [vlc_pkg::TolW-1:0] tol_q;
  vlc_pkg::item_t           item, head;
  vlc_pkg::res_t            res;
  logic                     take, avail;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= vlc_pkg::TolW'(256);
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  assign item.first_of_event = first_of_event_i;
  assign item.is_shower      = is_shower_i;
  assign item.item_index     = item_index_i;
  assign item.pos_x          = pos_x_i;
  assign item.pos_y          = pos_y_i;
  assign item.pos_z          = pos_z_i;

  vlc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .item_i  (item),
    .full_o  (full_o),
    .take_i  (take),
    .avail_o (avail),
    .head_o  (head)
  );

  vlc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tol_i   (tol_q),
    .avail_i (avail),
    .head_i  (head),
    .take_o  (take),
    .empty_o (empty_o),
    .pop_i   (pop_i),
    .res_o   (res)
  );

  assign vertex_index_o = res.vertex_index;
  assign created_o      = res.created;
  assign table_full_o   = res.table_full;
  assign member_count_o = res.member_count;
  assign centroid_x_o   = res.centroid_x;
  assign centroid_y_o   = res.centroid_y;
  assign centroid_z_o   = res.centroid_z;
  assign echo_index_o   = res.echo_index;
  assign echo_kind_o    = res.echo_kind;

endmodule

@@ hdl/vlc_checker.sv @@
`timescale 1ns / 1ps
`include "vertex_leader_clustering_assert.svh"
module vlc_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          empty_o,
  input logic                          pop_i,
  input logic [vlc_pkg::OutVidxW-1:0]  vertex_index_o,
  input logic                          created_o,
  input logic                          table_full_o,
  input logic [vlc_pkg::CntW-1:0]      member_count_o,
  input logic [vlc_pkg::IdxW-1:0]      echo_index_o
);

  `VLC_ASSERT(a_flags_excl, !empty_o |-> !(created_o && table_full_o), "created and full together")
  `VLC_ASSERT(a_full_word, (!empty_o && table_full_o) |-> (member_count_o == '0 && vertex_index_o == '0), "dropped word not zeroed")
  `VLC_ASSERT(a_new_count, (!empty_o && created_o) |-> (member_count_o == 16'd1), "new vertex count not one")
  `VLC_ASSERT(a_hold, (!empty_o && !pop_i) |=> (!empty_o && $stable(echo_index_o)), "result word dropped while stalled")
  `VLC_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> empty_o, "result present in reset")

endmodule

bind vertex_leader_clustering vlc_checker u_vlc_checker (.*);

@@ verif/tb_vertex_leader_clustering.sv @@
`timescale 1ns / 1ps
module tb_vertex_leader_clustering;

  localparam int unsigned CycleLimit = 8000000;
  localparam int unsigned NumItems   = 2000;
  localparam int          CoordMax   = 8388607;
  localparam int          CoordMin   = -8388608;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              push_i = 1'b0;
  logic                              full_o;
  logic                              first_of_event_i = 1'b0;
  logic                              is_shower_i = 1'b0;
  logic [vlc_pkg::IdxW-1:0]          item_index_i = '0;
  logic signed [vlc_pkg::CoordW-1:0] pos_x_i = '0;
  logic signed [vlc_pkg::CoordW-1:0] pos_y_i = '0;
  logic signed [vlc_pkg::CoordW-1:0] pos_z_i = '0;
  logic                              empty_o;
  logic                              pop_i = 1'b0;
  logic [vlc_pkg::OutVidxW-1:0]      vertex_index_o;
  logic                              created_o;
  logic                              table_full_o;
  logic [vlc_pkg::CntW-1:0]          member_count_o;
  logic signed [vlc_pkg::CoordW-1:0] centroid_x_o;
  logic signed [vlc_pkg::CoordW-1:0] centroid_y_o;
  logic signed [vlc_pkg::CoordW-1:0] centroid_z_o;
  logic [vlc_pkg::IdxW-1:0]          echo_index_o;
  logic                              echo_kind_o;
  logic                              cfg_we_i = 1'b0;
  logic [vlc_pkg::TolW-1:0]          cfg_wdata_i = '0;

  vertex_leader_clustering dut (
    .clk_i, .rst_ni, .push_i, .full_o, .first_of_event_i, .is_shower_i,
    .item_index_i, .pos_x_i, .pos_y_i, .pos_z_i, .empty_o, .pop_i,
    .vertex_index_o, .created_o, .table_full_o, .member_count_o,
    .centroid_x_o, .centroid_y_o, .centroid_z_o, .echo_index_o, .echo_kind_o,
    .cfg_we_i, .cfg_wdata_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the vertex table and the tolerance register
  longint          centroid_q [vlc_pkg::MaxVertices][3];
  int unsigned     members_q  [vlc_pkg::MaxVertices];
  int unsigned     open_vertices;
  longint unsigned tol_q;

  vlc_pkg::res_t pending_words[$];
  bit          failed;
  int unsigned tx_idle, rx_idle;
  int unsigned cycles;
  bit          hold_req;
  int unsigned items_sent;

  typedef struct {
    vlc_pkg::item_t it;
    bit             typed;
    vlc_pkg::res_t  want;
  } row_t;

  function automatic longint abs_l(longint d);
    return d < 0 ? -d : d;
  endfunction

  function automatic longint mean_step(longint c, longint p, int unsigned n);
    longint num, den, q;
    num = longint'(n) * c + p;
    den = longint'(n) + 1;
    q   = (abs_l(num) + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic bit near_vertex(int unsigned v, longint p[3]);
    longint unsigned sum, a;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      a = abs_l(p[k] - centroid_q[v][k]);
      if (a > tol_q) return 1'b0;
      sum += a * a;
    end
    return sum <= tol_q * tol_q;
  endfunction

  function automatic vlc_pkg::res_t assign_vertex(vlc_pkg::item_t it);
    vlc_pkg::res_t r;
    longint p[3];
    int unsigned v;
    bit     hit;
    r = '0;
    r.echo_index = it.item_index;
    r.echo_kind  = it.is_shower;
    hit = 1'b0;
    if (it.first_of_event) open_vertices = 0;
    p[0] = longint'($signed(it.pos_x));
    p[1] = longint'($signed(it.pos_y));
    p[2] = longint'($signed(it.pos_z));
    for (v = 0; v < open_vertices; v++) begin
      if (near_vertex(v, p)) begin
        for (int k = 0; k < 3; k++)
          centroid_q[v][k] = mean_step(centroid_q[v][k], p[k], members_q[v]);
        if (members_q[v] < 65535) members_q[v]++;
        hit = 1'b1;
        break;
      end
    end
    if (!hit) begin
      if (open_vertices >= vlc_pkg::MaxVertices) begin
        r.table_full = 1'b1;
        return r;
      end
      v = open_vertices;
      for (int k = 0; k < 3; k++) centroid_q[v][k] = p[k];
      members_q[v] = 1;
      open_vertices++;
      r.created = 1'b1;
    end
    r.vertex_index = v[vlc_pkg::OutVidxW-1:0];
    r.member_count = members_q[v][vlc_pkg::CntW-1:0];
    r.centroid_x   = centroid_q[v][0][vlc_pkg::CoordW-1:0];
    r.centroid_y   = centroid_q[v][1][vlc_pkg::CoordW-1:0];
    r.centroid_z   = centroid_q[v][2][vlc_pkg::CoordW-1:0];
    return r;
  endfunction

  task automatic cmp_field(string nm, longint unsigned e, longint unsigned a);
    if (e !== a) begin
      $error("%s mismatch: expected %0h, got %0h", nm, e, a);
      failed = 1'b1;
    end
  endtask

  task automatic offer(vlc_pkg::item_t it, bit typed, vlc_pkg::res_t want);
    vlc_pkg::res_t r;
    while ($urandom_range(99) < tx_idle) begin
      push_i = 1'b0;
      @(negedge clk_i);
    end
    first_of_event_i = it.first_of_event;
    is_shower_i      = it.is_shower;
    item_index_i     = it.item_index;
    pos_x_i          = it.pos_x;
    pos_y_i          = it.pos_y;
    pos_z_i          = it.pos_z;
    push_i           = 1'b1;
    do @(posedge clk_i); while (full_o);
    r = assign_vertex(it);
    if (typed) r = want;
    pending_words = {pending_words, r};
    items_sent++;
    @(negedge clk_i);
    push_i = 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_tol(logic [vlc_pkg::TolW-1:0] val);
    drain();
    cfg_wdata_i = val;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    tol_q       = val;
  endtask

  function automatic vlc_pkg::item_t rand_item();
    vlc_pkg::item_t it;
    it = $bits(vlc_pkg::item_t)'({$urandom, $urandom, $urandom});
    return it;
  endfunction

  function automatic logic [vlc_pkg::CoordW-1:0] jitter(logic [vlc_pkg::CoordW-1:0] c,
                                                        int unsigned spread);
    return c + vlc_pkg::CoordW'($urandom_range(2 * spread) - spread);
  endfunction

  // Result side: random pops, long hold-off on request
  initial begin : rx_proc
    int unsigned hold;
    vlc_pkg::res_t got, exp_w;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold     = 600;
        hold_req = 1'b0;
      end
      if (hold != 0) begin
        hold--;
        pop_i = 1'b0;
      end else begin
        pop_i = ($urandom_range(99) >= rx_idle);
      end
      @(posedge clk_i);
      if (pop_i && !empty_o) begin
        got = '{vertex_index_o, created_o, table_full_o, member_count_o, centroid_x_o,
                centroid_y_o, centroid_z_o, echo_index_o, echo_kind_o};
        if (pending_words.size() == 0) begin
          $error("result word with nothing expected");
          failed = 1'b1;
        end else begin
          exp_w = pending_words.pop_front();
          cmp_field("vertex_index", exp_w.vertex_index, got.vertex_index);
          cmp_field("created", exp_w.created, got.created);
          cmp_field("table_full", exp_w.table_full, got.table_full);
          cmp_field("member_count", exp_w.member_count, got.member_count);
          cmp_field("centroid_x", exp_w.centroid_x, got.centroid_x);
          cmp_field("centroid_y", exp_w.centroid_y, got.centroid_y);
          cmp_field("centroid_z", exp_w.centroid_z, got.centroid_z);
          cmp_field("echo_index", exp_w.echo_index, got.echo_index);
          cmp_field("echo_kind", exp_w.echo_kind, got.echo_kind);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin : main_proc
    row_t  rows[$];
    row_t  rw;
    vlc_pkg::item_t it, seeds[6];
    int unsigned tols[6], nseed, len, spread, mode;
    tols = '{0, 1, 16777215, 256, 4096, 100000};
    tx_idle = 13;
    rx_idle = 72;
    tol_q = 256;
    open_vertices = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: origin, extremes, boundary and rounding cases at reset tolerance
    rw = '{'{1, 0, 16'h0000, 0, 0, 0}, 1, '{0, 1, 0, 1, 0, 0, 0, 16'h0000, 0}};
    rows = {rows, rw};
    rw = '{'{0, 1, 16'hFFFF, CoordMax, CoordMax, CoordMax}, 1,
           '{1, 1, 0, 1, CoordMax, CoordMax, CoordMax, 16'hFFFF, 1}};
    rows = {rows, rw};
    rw = '{'{0, 0, 16'h8000, CoordMin, CoordMin, CoordMin}, 1,
           '{2, 1, 0, 1, CoordMin, CoordMin, CoordMin, 16'h8000, 0}};
    rows = {rows, rw};
    rw = '{'{0, 1, 16'h0001, 1, 0, 0}, 0, '0};  rows = {rows, rw};
    rw = '{'{0, 0, 16'h0002, -1, -1, 0}, 0, '0}; rows = {rows, rw};
    rw = '{'{0, 0, 16'h0003, 256, 0, 0}, 0, '0}; rows = {rows, rw};
    rw = '{'{0, 0, 16'h0004, 257, 0, 0}, 0, '0}; rows = {rows, rw};
    rw = '{'{0, 0, 16'h0005, 181, 181, 0}, 0, '0}; rows = {rows, rw};
    rw = '{'{0, 1, 16'h0006, CoordMax - 256, CoordMax, CoordMax}, 0, '0};
    rows = {rows, rw};
    rw = '{'{0, 0, 16'h0007, CoordMin + 100, CoordMin, CoordMin + 3}, 0, '0};
    rows = {rows, rw};
    rw = '{'{1, 1, 16'h5555, -5, 7, -9}, 1, '{0, 1, 0, 1, -5, 7, -9, 16'h5555, 1}};
    rows = {rows, rw};
    rw = '{'{0, 0, 16'hAAAA, -6, 7, -9}, 0, '0}; rows = {rows, rw};
    rw = '{'{0, 0, 16'h00FF, -4, 8, -10}, 0, '0}; rows = {rows, rw};
    // hold off the receiver so the input side fills and stalls
    hold_req = 1'b1;
    foreach (rows[i]) offer(rows[i].it, rows[i].typed, rows[i].want);

    // Zero tolerance: only exact repeats match
    write_tol(vlc_pkg::TolW'(0));
    it = '{1, 0, 16'h0010, 12, -12, 3};
    offer(it, 0, '0);
    offer(it, 0, '0);
    it.first_of_event = 0;
    it.pos_x = 13;
    offer(it, 0, '0);

    // Random part, phases of idle settings with random tolerance writes
    while (items_sent < NumItems) begin
      if (items_sent > 2 * NumItems / 3) begin
        tx_idle = 0;
        rx_idle = 0;
      end else if (items_sent > NumItems / 3) begin
        tx_idle = 72;
        rx_idle = 13;
      end
      if ($urandom_range(3) == 0) write_tol(vlc_pkg::TolW'(tols[$urandom_range(5)]));
      else if ($urandom_range(2) == 0) write_tol(vlc_pkg::TolW'($urandom));
      if ($urandom_range(4) == 0) hold_req = 1'b1;
      mode = $urandom_range(9);
      spread = (tol_q > 1048576) ? 1048576 : int'(tol_q[31:0]) + 2;
      if (mode < 6) begin
        // Clusters around a few seeds
        nseed = $urandom_range(1, 6);
        for (int s = 0; s < 6; s++) seeds[s] = rand_item();
        len = $urandom_range(5, 30);
        for (int n = 0; n < len; n++) begin
          it = rand_item();
          it.first_of_event = (n == 0);
          rw.it = seeds[$urandom_range(nseed - 1)];
          it.pos_x = jitter(rw.it.pos_x, spread);
          it.pos_y = jitter(rw.it.pos_y, spread);
          it.pos_z = jitter(rw.it.pos_z, spread);
          offer(it, 0, '0);
        end
      end else if (mode < 8) begin
        // Spread points far apart to fill the table and overflow it
        len = $urandom_range(60, 72);
        if (tol_q > 65536) write_tol(vlc_pkg::TolW'($urandom_range(0, 300)));
        for (int n = 0; n < len; n++) begin
          it = rand_item();
          it.first_of_event = (n == 0);
          if ($urandom_range(7) == 0) begin
            it.pos_x = ($urandom_range(1)) ? vlc_pkg::CoordW'(CoordMax) :
                                             vlc_pkg::CoordW'(CoordMin);
          end
          offer(it, 0, '0);
        end
      end else begin
        len = $urandom_range(3, 15);
        for (int n = 0; n < len; n++) offer(rand_item(), 0, '0);
      end
    end

    drain();
    repeat (600) @(negedge clk_i);
    if (!failed && pending_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
